// ===== src/clmnd_pkg.sv =====
// Shared types and constants for the character LCD marquee nibble driver.
// No dependencies; every module of the block but clmnd_checker imports this package.
package clmnd_pkg;

	// Default sizes handed down from the top level
	localparam int unsigned BUFFER_LEN_DEF   = 40;
	localparam int unsigned VISIBLE_COLS_DEF = 16;

	// Position counters (write, read, scroll offset)
	localparam int unsigned POS_W = 6;

	// Command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Instruction bytes
	localparam logic [7:0] INSTR_SET_DDRAM  = 8'h80;
	localparam logic [7:0] INSTR_SHIFT      = 8'h10;
	localparam logic [7:0] SHIFT_LEFT_BITS  = 8'h08;
	localparam logic [7:0] SHIFT_RIGHT_BITS = 8'h0C;

	// Saturation limit of the scroll offset
	localparam logic [POS_W-1:0] OFFSET_MAX = {POS_W{1'b1}};

	// Input request codes; code 3 is unused and ignored
	typedef enum logic [1:0] {
		MODE_PUT   = 2'd0,
		MODE_SYNC  = 2'd1,
		MODE_SHIFT = 2'd2
	} mode_t;

	// Nibble position within a queued command
	typedef enum logic [1:0] {
		STEP_INSTR_HI = 2'd0,
		STEP_INSTR_LO = 2'd1,
		STEP_DATA_HI  = 2'd2,
		STEP_DATA_LO  = 2'd3
	} step_t;

	// One queued command: an instruction byte, optionally followed by a data byte
	typedef struct packed {
		logic       is_sync;
		logic [7:0] instr;
		logic [7:0] data;
	} cmd_t;

endpackage

// ===== src/clmnd_front.sv =====
// Front end: accepts requests, owns the text buffer and position state,
// and turns sync/shift requests into queued commands. Uses clmnd_pkg.
module clmnd_front #(
	parameter int unsigned BUFFER_LEN   = clmnd_pkg::BUFFER_LEN_DEF,
	parameter int unsigned VISIBLE_COLS = clmnd_pkg::VISIBLE_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [7:0]         char_code,
	output logic               push_valid,
	input  logic               push_ready,
	output clmnd_pkg::cmd_t    push_cmd
);
	import clmnd_pkg::*;

	localparam int unsigned AW = $clog2(BUFFER_LEN);
	localparam logic [POS_W-1:0] BUF_LEN_P = POS_W'(BUFFER_LEN);
	localparam logic [POS_W-1:0] VIS_P     = POS_W'(VISIBLE_COLS);

	logic [7:0]       text_mem [BUFFER_LEN];
	logic [POS_W-1:0] write_pos_q, read_pos_q, scroll_offset_q;
	logic             scroll_right_q;

	logic             s1_valid_q;
	logic             s1_is_sync_s1;
	logic [7:0]       s1_instr_s1;
	logic [7:0]       rd_data_s1;

	logic             in_fire;
	logic             do_put, do_sync, do_shift;
	logic             s1_ready;
	logic [POS_W-1:0] offset_next;
	logic             right_next;
	logic [7:0]       shift_cmd;

	// Stage 1 frees when empty or when its command moves into the queue
	assign s1_ready = !s1_valid_q || push_ready;
	assign in_ready = s1_ready;
	assign in_fire  = in_valid && in_ready;

	// Classify the request
	always_comb begin
		do_put   = 1'b0;
		do_sync  = 1'b0;
		do_shift = 1'b0;
		unique case (mode_t'(mode))
			MODE_PUT:   do_put   = write_pos_q < BUF_LEN_P;
			MODE_SYNC:  do_sync  = read_pos_q < write_pos_q;
			MODE_SHIFT: do_shift = read_pos_q > VIS_P;
			default:    ;
		endcase
	end

	// Bouncing scroll offset
	always_comb begin
		offset_next = scroll_offset_q;
		right_next  = scroll_right_q;
		if (!scroll_right_q) begin
			if (scroll_offset_q != OFFSET_MAX)
				offset_next = scroll_offset_q + POS_W'(1);
			if (offset_next > (read_pos_q - VIS_P))
				right_next = 1'b1;
		end else begin
			if (scroll_offset_q != '0)
				offset_next = scroll_offset_q - POS_W'(1);
			if (offset_next == '0)
				right_next = 1'b0;
		end
	end

	assign shift_cmd = INSTR_SHIFT | (scroll_right_q ? SHIFT_RIGHT_BITS : SHIFT_LEFT_BITS);

	// Position and scroll state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q     <= '0;
			read_pos_q      <= '0;
			scroll_offset_q <= '0;
			scroll_right_q  <= 1'b0;
		end else if (in_fire) begin
			if (do_put)
				write_pos_q <= write_pos_q + POS_W'(1);
			if (do_sync)
				read_pos_q <= read_pos_q + POS_W'(1);
			if (do_shift) begin
				scroll_offset_q <= offset_next;
				scroll_right_q  <= right_next;
			end
		end
	end

	// Text buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_fire && do_put)
			text_mem[write_pos_q[AW-1:0]] <= char_code;
		if (in_fire && do_sync)
			rd_data_s1 <= text_mem[read_pos_q[AW-1:0]];
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (s1_ready)
			s1_valid_q <= in_fire && (do_sync || do_shift);
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire && (do_sync || do_shift)) begin
			s1_is_sync_s1 <= do_sync;
			s1_instr_s1   <= do_sync ? (INSTR_SET_DDRAM | {2'b00, read_pos_q}) : shift_cmd;
		end
	end

	assign push_valid       = s1_valid_q;
	assign push_cmd.is_sync = s1_is_sync_s1;
	assign push_cmd.instr   = s1_instr_s1;
	assign push_cmd.data    = rd_data_s1;

endmodule

// ===== src/clmnd_queue.sv =====
// Small command queue decoupling the front end from the nibble sequencer.
// Uses clmnd_pkg for the command type and depth.
module clmnd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  clmnd_pkg::cmd_t    push_cmd,
	output logic               pop_valid,
	input  logic               pop_ready,
	output clmnd_pkg::cmd_t    pop_cmd
);
	import clmnd_pkg::*;

	localparam int unsigned IW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [IW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push_fire, pop_fire;

	assign push_ready = count_q != CW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_cmd    = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire)
				wr_ptr_q <= (wr_ptr_q == IW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + IW'(1);
			if (pop_fire)
				rd_ptr_q <= (rd_ptr_q == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + IW'(1);
			if (push_fire && !pop_fire)
				count_q <= count_q + CW'(1);
			else if (pop_fire && !push_fire)
				count_q <= count_q - CW'(1);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push_fire)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== src/clmnd_back.sv =====
// Back end: splits each queued command into bus nibbles, upper half first.
// Uses clmnd_pkg for the command type and step codes.
module clmnd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  clmnd_pkg::cmd_t    pop_cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               reg_select,
	output logic [3:0]         nibble,
	output logic               last
);
	import clmnd_pkg::*;

	logic  busy_q;
	cmd_t  cur_q;
	step_t step_q;
	logic  out_fire;
	logic  at_end;

	assign out_valid = busy_q;
	assign out_fire  = busy_q && out_ready;
	assign at_end    = cur_q.is_sync ? (step_q == STEP_DATA_LO) : (step_q == STEP_INSTR_LO);
	// Load the next command when idle or as the current one finishes
	assign pop_ready = !busy_q || (out_fire && at_end);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_INSTR_HI;
		end else if (pop_ready) begin
			busy_q <= pop_valid;
			step_q <= STEP_INSTR_HI;
		end else if (out_fire) begin
			step_q <= step_t'(step_q + 2'd1);
		end
	end

	// Current command
	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid)
			cur_q <= pop_cmd;
	end

	// Nibble select
	always_comb begin
		unique case (step_q)
			STEP_INSTR_HI: nibble = cur_q.instr[7:4];
			STEP_INSTR_LO: nibble = cur_q.instr[3:0];
			STEP_DATA_HI:  nibble = cur_q.data[7:4];
			STEP_DATA_LO:  nibble = cur_q.data[3:0];
			default:       nibble = cur_q.instr[7:4];
		endcase
	end

	assign reg_select = (step_q == STEP_DATA_HI) || (step_q == STEP_DATA_LO);
	assign last       = at_end;

endmodule

// ===== src/char_lcd_marquee_nibble_driver_core.sv =====
// Top level of the character LCD marquee nibble driver.
// Instantiates clmnd_front, clmnd_queue and clmnd_back; uses clmnd_pkg.
//
// A put request stores one character in a BUFFER_LEN-deep text buffer, a
// sync request sends the next unsent character as a set-address instruction
// plus data (four nibbles), and a shift request sends a display-shift
// instruction (two nibbles) once more than VISIBLE_COLS characters are out.
// The input side takes one request per cycle while in_ready is high. A
// request's nibbles pass stage 1, the command queue and the back end's
// command register, then leave one per cycle while out_ready is high. The
// single nibble output sets the sustained rate: a sync costs four nibbles,
// a shift two, a put or an ignored request none. A two-entry queue plus one
// front register let requests flow while earlier nibbles wait for out_ready.
module char_lcd_marquee_nibble_driver_core #(
	parameter int unsigned BUFFER_LEN   = clmnd_pkg::BUFFER_LEN_DEF,
	parameter int unsigned VISIBLE_COLS = clmnd_pkg::VISIBLE_COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       reg_select,
	output logic [3:0] nibble,
	output logic       last
);
	import clmnd_pkg::*;

	logic push_valid, push_ready;
	logic pop_valid, pop_ready;
	cmd_t push_cmd, pop_cmd;

	clmnd_front #(
		.BUFFER_LEN   (BUFFER_LEN),
		.VISIBLE_COLS (VISIBLE_COLS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.char_code  (char_code),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	clmnd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	clmnd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.reg_select (reg_select),
		.nibble     (nibble),
		.last       (last)
	);

endmodule

// ===== src/clmnd_checker.sv =====
// Port-level checks on the nibble output of the marquee driver.
// Bound to char_lcd_marquee_nibble_driver_core; no package dependency.
module clmnd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       reg_select,
	input logic [3:0] nibble,
	input logic       last
);

	// A stalled transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(nibble) &&
			$stable(reg_select) && $stable(last))
		else $error("output transaction changed while stalled");

	// The nibbles of one byte sequence leave back to back
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a request's nibble sequence");

	// The upper data nibble is always followed by the closing lower one
	a_data_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && reg_select && !last |=> reg_select && last)
		else $error("data byte not closed by its lower nibble");

endmodule

bind char_lcd_marquee_nibble_driver_core clmnd_checker u_clmnd_checker (.*);
